// ----- rtl/core/losg_pkg.sv -----
package losg_pkg;

  localparam int unsigned InW      = 208;
  localparam int unsigned OutW     = 96;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CordicSteps = 20;

  localparam logic [15:0] PiQ13 = 16'd25736;
  localparam logic [24:0] PiQ20 = 25'd3294199;

  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_STEER   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_STEER   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED_KP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPEED_KI_T  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STEER_KP    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_INV_THRESH  = 3'd7;

  typedef enum logic [4:0] {
    OP_IDLE, OP_SQ_AX, OP_SQ_AY, OP_SUM_D, OP_SQRT_D, OP_SQ_VX, OP_SQ_VY,
    OP_SUM_V, OP_SQRT_V, OP_MUL_T, OP_MUL_TH, OP_MUL_TL, OP_REF, OP_MUL_I,
    OP_INTEG, OP_MUL_C, OP_CMD, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic sqrt_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [31:0] min_speed;
    logic [15:0] min_steer;
    logic [15:0] max_steer;
    logic [15:0] speed_kp;
    logic [15:0] speed_ki_t;
    logic [15:0] steer_kp;
    logic [23:0] inv_thresh;
  } cfg_t;

  // Arctangent of 2^-i in Q.20 radians.
  function automatic logic [19:0] atan_f(input logic [4:0] i);
    logic [19:0] v;
    unique case (i)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/losg_ctrl.sv -----
module losg_ctrl
  import losg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQ_AX  = 5'd1;
  localparam logic [4:0] S_SQRT_D = 5'd4;
  localparam logic [4:0] S_SQ_VX  = 5'd5;
  localparam logic [4:0] S_SQRT_V = 5'd8;
  localparam logic [4:0] S_MUL_T  = 5'd9;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op_e'(state_q);
  assign cmd_o.load = in_ready_o & in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SQ_AX;
      S_SQRT_D: if (stat_i.sqrt_last) state_d = S_SQ_VX;
      S_SQRT_V: if (stat_i.sqrt_last) state_d = S_MUL_T;
      S_OUT:    if (stat_i.out_free) state_d = S_IDLE;
      default: begin
        if (state_q < S_OUT) state_d = state_q + 5'd1;
        else state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ----- rtl/core/losg_dp.sv -----
module losg_dp
  import losg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output stat_t           stat_o,
  input  cfg_t            cfg_i,
  input  logic [InW-1:0]  in_data_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [OutW-1:0] out_data_o
);

  function automatic logic [31:0] sat32_f(input logic signed [51:0] v);
    logic [31:0] r;
    if (v > 52'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -52'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  op_e op;
  assign op = cmd_i.op;

  // Input capture
  logic signed [32:0] dx_in, dy_in;
  logic [32:0] ax_in, ay_in, ax_q, ay_q;
  logic [31:0] vx_q, vy_q, vx_mag, vy_mag;
  logic signed [15:0] hd_q;
  logic big_q;

  assign dx_in = $signed({in_data_i[31], in_data_i[31:0]})
               - $signed({in_data_i[95], in_data_i[95:64]});
  assign dy_in = $signed({in_data_i[63], in_data_i[63:32]})
               - $signed({in_data_i[127], in_data_i[127:96]});
  assign ax_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
  assign ay_in = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
  assign vx_mag = vx_q[31] ? (32'd0 - vx_q) : vx_q;
  assign vy_mag = vy_q[31] ? (32'd0 - vy_q) : vy_q;

  // CORDIC vectoring
  logic signed [35:0] x_q, y_q, xs, ys;
  logic signed [24:0] z_q, atan_s;
  logic zero_q;
  logic [4:0] cnt_q;
  logic cordic_run;

  assign cordic_run = (op == OP_SQRT_D) && (cnt_q < 5'(CordicSteps));
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign atan_s = $signed({5'd0, atan_f(cnt_q)});

  logic signed [17:0] z_rnd;
  logic signed [15:0] angle;
  assign z_rnd = 18'((z_q + 25'sd64) >>> 7);
  always_comb begin
    if (zero_q) angle = 16'sd0;
    else if (z_rnd > $signed({2'b0, PiQ13})) angle = $signed(PiQ13);
    else if (z_rnd < -$signed({2'b0, PiQ13})) angle = -$signed(PiQ13);
    else angle = z_rnd[15:0];
  end

  // Square root, one result bit per cycle
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [35:0] rem_q, rem_n, trial;
  logic ge;
  assign rem_n = {rem_q[33:0], rad_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  // Shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] mul_q;
  logic [30:0] dist_q;
  logic [31:0] spd_q;
  logic [22:0] tl_q;
  logic [46:0] hi_q;
  logic [31:0] err_q, integ_q, last_q, cmd_q;
  logic signed [32:0] sum_i, sum_c;
  logic signed [16:0] r_steer;

  assign sum_i = $signed({last_q[31], last_q}) + $signed({err_q[31], err_q});
  assign sum_c = $signed({err_q[31], err_q}) + $signed({integ_q[31], integ_q});

  // Heading error reduced modulo pi by truncation
  logic signed [16:0] diff;
  logic [16:0] dmag, dred;
  assign diff = $signed({angle[15], angle}) - $signed({hd_q[15], hd_q});
  assign dmag = diff[16] ? 17'(-diff) : 17'(diff);
  always_comb begin
    if (dmag >= {PiQ13, 1'b0}) dred = dmag - {PiQ13, 1'b0};
    else if (dmag >= {1'b0, PiQ13}) dred = dmag - {1'b0, PiQ13};
    else dred = dmag;
  end
  assign r_steer = diff[16] ? -$signed(dred) : $signed(dred);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (op)
      OP_SQ_AX:  begin ma = $signed({1'b0, ax_q}); mb = ma; end
      OP_SQ_AY:  begin ma = $signed({1'b0, ay_q}); mb = ma; end
      OP_SQ_VX:  begin ma = $signed({2'b0, vx_mag}); mb = ma; end
      OP_SQ_VY:  begin ma = $signed({2'b0, vy_mag}); mb = ma; end
      OP_MUL_T:  begin
        ma = $signed({3'b0, cfg_i.max_speed}); mb = $signed({3'b0, dist_q});
      end
      OP_MUL_TH: begin
        ma = $signed({11'b0, mul_q[61:39]}); mb = $signed({10'b0, cfg_i.inv_thresh});
      end
      OP_MUL_TL: begin
        ma = $signed({11'b0, tl_q}); mb = $signed({10'b0, cfg_i.inv_thresh});
      end
      OP_MUL_I:  begin
        ma = $signed({18'b0, cfg_i.speed_ki_t}); mb = 34'(sum_i);
      end
      OP_MUL_C:  begin
        ma = $signed({18'b0, cfg_i.speed_kp}); mb = 34'(sum_c);
      end
      OP_CMD:    begin
        ma = $signed({18'b0, cfg_i.steer_kp}); mb = 34'(r_steer);
      end
      default: ;
    endcase
  end

  // Speed reference and error
  logic [69:0] prod;
  logic [30:0] spd_ref;
  logic signed [33:0] err34;
  assign prod = {hi_q, 23'b0} + {23'b0, mul_q[46:0]};
  always_comb begin
    if (cfg_i.inv_thresh == 24'd0) spd_ref = '0;
    else if (|prod[69:64]) spd_ref = cfg_i.max_speed;
    else if (prod[63:16] > {17'b0, cfg_i.max_speed}) spd_ref = cfg_i.max_speed;
    else spd_ref = prod[46:16];
  end
  assign err34 = $signed({3'b0, spd_ref}) - $signed({2'b0, spd_q});

  logic signed [51:0] integ_sum;
  assign integ_sum = $signed({{20{integ_q[31]}}, integ_q}) + $signed(mul_q[68-1:17-1+1]);

  // Output clamps
  logic signed [59:0] cmd_v, stv, cmd_c, st_c;
  assign cmd_v = 60'(mul_q >>> 8);
  assign stv   = 60'(mul_q >>> 8);
  always_comb begin
    cmd_c = cmd_v;
    if (cmd_c < $signed({{28{cfg_i.min_speed[31]}}, cfg_i.min_speed}))
      cmd_c = $signed({{28{cfg_i.min_speed[31]}}, cfg_i.min_speed});
    if (cmd_c > $signed({29'b0, cfg_i.max_speed})) cmd_c = $signed({29'b0, cfg_i.max_speed});
    st_c = stv;
    if (st_c < $signed({{44{cfg_i.min_steer[15]}}, cfg_i.min_steer}))
      st_c = $signed({{44{cfg_i.min_steer[15]}}, cfg_i.min_steer});
    if (st_c > $signed({{44{cfg_i.max_steer[15]}}, cfg_i.max_steer}))
      st_c = $signed({{44{cfg_i.max_steer[15]}}, cfg_i.max_steer});
  end

  logic out_valid_q;
  logic [OutW-1:0] out_data_q;

  assign stat_o.sqrt_last = (cnt_q == 5'd31);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= ax_in;
      ay_q  <= ay_in;
      big_q <= ax_in[32] | ax_in[31] | ay_in[32] | ay_in[31];
      vx_q  <= in_data_i[159:128];
      vy_q  <= in_data_i[191:160];
      hd_q  <= $signed(in_data_i[207:192]);
      zero_q <= (dx_in == 33'sd0) && (dy_in == 33'sd0);
      if (dx_in[32]) begin
        x_q <= -36'(dx_in);
        y_q <= -36'(dy_in);
        z_q <= dy_in[32] ? -$signed(PiQ20) : $signed(PiQ20);
      end else begin
        x_q <= 36'(dx_in);
        y_q <= 36'(dy_in);
        z_q <= '0;
      end
    end
    if (cordic_run) begin
      if (y_q > 36'sd0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_s;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_s;
      end
    end

    // The steer product must stay put while the result waits for the output register.
    if (op != OP_OUT) mul_q <= ma * mb;

    unique case (op)
      OP_SQ_AY, OP_SQ_VY: rad_q <= mul_q[63:0];
      OP_SUM_D, OP_SUM_V: begin
        rad_q  <= rad_q + mul_q[63:0];
        root_q <= '0;
        rem_q  <= '0;
      end
      OP_SQRT_D, OP_SQRT_V: begin
        rem_q  <= ge ? (rem_n - trial) : rem_n;
        root_q <= {root_q[30:0], ge};
        rad_q  <= {rad_q[61:0], 2'b00};
      end
      OP_SQ_VX:  dist_q <= (big_q || root_q[31]) ? '1 : root_q[30:0];
      OP_MUL_T:  spd_q <= root_q;
      OP_MUL_TH: tl_q <= mul_q[38:16];
      OP_MUL_TL: hi_q <= mul_q[46:0];
      OP_REF:    err_q <= sat32_f(52'(err34));
      OP_CMD:    cmd_q <= cmd_c[31:0];
      default: ;
    endcase

    if (op == OP_OUT && stat_o.out_free)
      out_data_q <= {1'b0, angle, dist_q, st_c[15:0], cmd_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      integ_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op == OP_SUM_D || op == OP_SUM_V) cnt_q <= '0;
      else if (op == OP_SQRT_D || op == OP_SQRT_V) cnt_q <= cnt_q + 5'd1;
      if (op == OP_INTEG) begin
        integ_q <= sat32_f(integ_sum);
        last_q  <= err_q;
      end
      if (op == OP_OUT && stat_o.out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/line_of_sight_speed_steer_guidance.sv -----
// Input words are taken only while idle; each word passes through two bit-serial
// square roots on one shared root unit plus the multiply steps on one shared
// multiplier before the next word is accepted.
// A finished result waits in the output register while the next word is taken.
// Reset clears the configuration registers to their defaults and the previous
// speed error and the integral state to zero.
module line_of_sight_speed_steer_guidance
  import losg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // target_x, target_y, pos_x, pos_y, vel_x, vel_y, heading
  input  logic [InW-1:0]      s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // speed_command, steer_command, sight_distance, sight_angle, one pad bit
  output logic [OutW-1:0]     m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed  <= 31'd65536;
      cfg_q.min_speed  <= 32'd0;
      cfg_q.min_steer  <= 16'hF000;
      cfg_q.max_steer  <= 16'h1000;
      cfg_q.speed_kp   <= 16'd256;
      cfg_q.speed_ki_t <= 16'd0;
      cfg_q.steer_kp   <= 16'd256;
      cfg_q.inv_thresh <= 24'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_SPEED:  cfg_q.max_speed  <= cfg_data_i[30:0];
        REG_MIN_SPEED:  cfg_q.min_speed  <= cfg_data_i;
        REG_MIN_STEER:  cfg_q.min_steer  <= cfg_data_i[15:0];
        REG_MAX_STEER:  cfg_q.max_steer  <= cfg_data_i[15:0];
        REG_SPEED_KP:   cfg_q.speed_kp   <= cfg_data_i[15:0];
        REG_SPEED_KI_T: cfg_q.speed_ki_t <= cfg_data_i[15:0];
        REG_STEER_KP:   cfg_q.steer_kp   <= cfg_data_i[15:0];
        REG_INV_THRESH: cfg_q.inv_thresh <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  losg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  losg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_i       (cfg_q),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
